@@ hdl/psde_pkg.sv @@
// ----------------------------------------------------------------------------
// psde_pkg
// Shared types, constants and functions of the stored-deflate PNG encoder.
// ----------------------------------------------------------------------------
package psde_pkg;

  // default sizes and stored block length
  localparam int unsigned DEF_MAX_WIDTH   = 4096;
  localparam int unsigned DEF_MAX_HEIGHT  = 4096;
  localparam int unsigned DEF_BLOCK_BYTES = 65535;

  // field widths
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned INDEX_W = 8;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  // per-pixel result window
  localparam int unsigned RESULT_LIMIT  = 64;
  localparam int unsigned TRAILER_BYTES = 20;
  localparam int unsigned COUNT_W       = 7;

  // byte positions inside the header, block header and trailer
  localparam logic [5:0] HDR_IHDR_FIRST = 6'd12;
  localparam logic [5:0] HDR_IHDR_LAST  = 6'd28;
  localparam logic [5:0] HDR_CRC_FIRST  = 6'd29;
  localparam logic [5:0] HDR_ZLEN_FIRST = 6'd33;
  localparam logic [5:0] HDR_ZLEN_LAST  = 6'd36;
  localparam logic [5:0] HDR_IDAT_FIRST = 6'd37;
  localparam logic [5:0] HDR_LAST       = 6'd42;
  localparam logic [5:0] HDR_DIV_START  = 6'd1;
  localparam logic [5:0] BLK_LAST       = 6'd4;
  localparam logic [5:0] TRL_ADLER_LAST = 6'd3;
  localparam logic [5:0] TRL_LAST       = 6'd19;

  // checksum constants
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
  localparam logic [31:0] IEND_CRC   = 32'hAE426082;
  localparam logic [16:0] ADLER_MOD  = 17'd65521;

  // datapath operation
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_HDR  = 3'd1,
    OP_BLK  = 3'd2,
    OP_RAW  = 3'd3,
    OP_TRL  = 3'd4
  } op_e;

  // raw byte of the current pixel
  typedef enum logic [2:0] {
    SEL_FILTER = 3'd0,
    SEL_RED    = 3'd1,
    SEL_GREEN  = 3'd2,
    SEL_BLUE   = 3'd3,
    SEL_ALPHA  = 3'd4
  } sel_e;

  typedef struct packed {
    op_e        op;
    logic [5:0] idx;
    sel_e       sel;
    logic       step;
    logic       emit;
    logic       run_end;
    logic       file_end;
    logic       load_pixel;
    logic       load_size;
    logic       hdr_calc;
    logic       div_start;
    logic       file_reset;
    logic       in_ready;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic pix_valid;
    logic block_empty;
    logic col_zero;
    logic col_last;
    logic row_last;
    logic div_busy;
  } status_t;

  // one byte into a reflected crc-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // big-endian byte of a word
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] pos);
    logic [7:0] r;
    case (pos)
      2'd0:    r = v[31:24];
      2'd1:    r = v[23:16];
      2'd2:    r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

endpackage

@@ hdl/psde_pix_if.sv @@
// ----------------------------------------------------------------------------
// psde_pix_if
// Pixel channel: one rgb pixel per transaction.
// ----------------------------------------------------------------------------
interface psde_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ hdl/psde_byte_if.sv @@
// ----------------------------------------------------------------------------
// psde_byte_if
// Byte channel: one byte of the png stream per transaction.
// ----------------------------------------------------------------------------
interface psde_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       file_end;

  modport source (output valid, output out_byte, output run_end, output file_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, input file_end, output ready);
endinterface

@@ hdl/psde_cfg_if.sv @@
// ----------------------------------------------------------------------------
// psde_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface psde_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/psde_div.sv @@
// ----------------------------------------------------------------------------
// psde_div
// Division by the stored block length through a constant reciprocal multiply.
// ----------------------------------------------------------------------------
module psde_div #(
  parameter int unsigned STORED_BLOCK_BYTES = psde_pkg::DEF_BLOCK_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);

  // reciprocal exact for every 32-bit dividend
  localparam int unsigned SHIFT = 32 + $clog2(STORED_BLOCK_BYTES);
  localparam logic [32:0] RECIP =
    33'(((64'd1 << SHIFT) + 64'(STORED_BLOCK_BYTES) - 64'd1) / 64'(STORED_BLOCK_BYTES));

  logic [31:0] num_q;
  logic [31:0] quo_q;
  logic        busy_q;
  logic [64:0] prod;

  // product of the latched dividend and the reciprocal
  assign prod = 65'(num_q) * 65'(RECIP);

  // busy for the one cycle in which the product is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  // dividend latch and quotient register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
    end
    if (busy_q) begin
      quo_q <= 32'(prod >> SHIFT);
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

@@ hdl/psde_ctrl.sv @@
// ----------------------------------------------------------------------------
// psde_ctrl
// Byte sequencer: walks header, block headers, pixel bytes and trailer.
// ----------------------------------------------------------------------------
module psde_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psde_pkg::status_t  status_i,
  output psde_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HDR  = 5'b00010,
    ST_BLK  = 5'b00100,
    ST_RAW  = 5'b01000,
    ST_TRL  = 5'b10000
  } state_e;

  localparam logic [psde_pkg::COUNT_W-1:0] CNT_LAST =
    psde_pkg::COUNT_W'(psde_pkg::RESULT_LIMIT - 1);
  localparam logic [psde_pkg::COUNT_W-1:0] CNT_FIT =
    psde_pkg::COUNT_W'(psde_pkg::RESULT_LIMIT - psde_pkg::TRAILER_BYTES - 1);

  state_e                        state_q, state_d;
  logic [5:0]                    idx_q, idx_d;
  psde_pkg::sel_e                sel_q, sel_d;
  logic [psde_pkg::COUNT_W-1:0]  cnt_q, cnt_d;
  logic                          hdr_done_q, hdr_done_d;
  logic                          pend_q, pend_d;
  logic                          drop, room, at_limit, img_end, fits, wait_div;
  psde_pkg::sel_e                sel_next;

  // next pixel byte
  always_comb begin
    case (sel_q)
      psde_pkg::SEL_FILTER: sel_next = psde_pkg::SEL_RED;
      psde_pkg::SEL_RED:    sel_next = psde_pkg::SEL_GREEN;
      psde_pkg::SEL_GREEN:  sel_next = psde_pkg::SEL_BLUE;
      default:              sel_next = psde_pkg::SEL_ALPHA;
    endcase
  end

  assign drop     = cnt_q[psde_pkg::COUNT_W-1];
  assign room     = drop || status_i.slot_free;
  assign at_limit = (cnt_q == CNT_LAST);
  assign img_end  = status_i.col_last && status_i.row_last;
  assign fits     = (cnt_q <= CNT_FIT);
  assign wait_div = (idx_q >= psde_pkg::HDR_ZLEN_FIRST) && (idx_q <= psde_pkg::HDR_ZLEN_LAST)
                    && status_i.div_busy;

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    sel_d      = sel_q;
    cnt_d      = cnt_q;
    hdr_done_d = hdr_done_q;
    pend_d     = pend_q;
    cmd_o          = '0;
    cmd_o.op       = psde_pkg::OP_NONE;
    cmd_o.idx      = idx_q;
    cmd_o.sel      = sel_q;
    cmd_o.in_ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (status_i.pix_valid) begin
          cmd_o.load_pixel = 1'b1;
          cnt_d = '0;
          idx_d = '0;
          sel_d = status_i.col_zero ? psde_pkg::SEL_FILTER : psde_pkg::SEL_RED;
          if (pend_q) begin
            state_d = ST_TRL;
          end else if (!hdr_done_q) begin
            cmd_o.load_size = 1'b1;
            state_d = ST_HDR;
          end else begin
            state_d = ST_RAW;
          end
        end
      end
      ST_HDR: begin
        cmd_o.op       = psde_pkg::OP_HDR;
        cmd_o.hdr_calc = (idx_q == '0);
        if (room && !wait_div) begin
          cmd_o.step      = 1'b1;
          cmd_o.emit      = !drop;
          cmd_o.run_end   = at_limit;
          cmd_o.div_start = (idx_q == psde_pkg::HDR_DIV_START);
          if (idx_q == psde_pkg::HDR_LAST) begin
            hdr_done_d = 1'b1;
            idx_d      = '0;
            state_d    = ST_RAW;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      ST_BLK: begin
        cmd_o.op = psde_pkg::OP_BLK;
        if (room) begin
          cmd_o.step    = 1'b1;
          cmd_o.emit    = !drop;
          cmd_o.run_end = at_limit;
          if (idx_q == psde_pkg::BLK_LAST) begin
            idx_d   = '0;
            state_d = ST_RAW;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      ST_RAW: begin
        if (status_i.block_empty) begin
          idx_d   = '0;
          state_d = ST_BLK;
        end else begin
          cmd_o.op = psde_pkg::OP_RAW;
          if (room) begin
            cmd_o.step    = 1'b1;
            cmd_o.emit    = !drop;
            cmd_o.run_end = at_limit ||
                            ((sel_q == psde_pkg::SEL_ALPHA) && !(img_end && fits));
            if (sel_q == psde_pkg::SEL_ALPHA) begin
              idx_d = '0;
              if (img_end && fits) begin
                state_d = ST_TRL;
              end else begin
                pend_d  = img_end;
                state_d = ST_IDLE;
              end
            end else begin
              sel_d = sel_next;
            end
          end
        end
      end
      ST_TRL: begin
        cmd_o.op = psde_pkg::OP_TRL;
        if (room) begin
          cmd_o.step     = 1'b1;
          cmd_o.emit     = !drop;
          cmd_o.run_end  = at_limit || (idx_q == psde_pkg::TRL_LAST);
          cmd_o.file_end = (idx_q == psde_pkg::TRL_LAST);
          if (idx_q == psde_pkg::TRL_LAST) begin
            cmd_o.file_reset = 1'b1;
            hdr_done_d = 1'b0;
            pend_d     = 1'b0;
            idx_d      = '0;
            state_d    = ST_IDLE;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // result count, saturating at the window size
    if (cmd_o.step && !drop) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      sel_q      <= psde_pkg::SEL_FILTER;
      cnt_q      <= '0;
      hdr_done_q <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      sel_q      <= sel_d;
      cnt_q      <= cnt_d;
      hdr_done_q <= hdr_done_d;
      pend_q     <= pend_d;
    end
  end

endmodule

@@ hdl/psde_dpath.sv @@
// ----------------------------------------------------------------------------
// psde_dpath
// Datapath: size registers, counters, checksums, byte mux and output register.
// ----------------------------------------------------------------------------
module psde_dpath #(
  parameter int unsigned MAX_WIDTH          = psde_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT         = psde_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned STORED_BLOCK_BYTES = psde_pkg::DEF_BLOCK_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  psde_pix_if.sink           pix_i,
  psde_byte_if.source        res_o,
  psde_cfg_if.sink           cfg_i,
  input  psde_pkg::cmd_t     cmd_i,
  output psde_pkg::status_t  status_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam logic [15:0] BLK_MAX = 16'(STORED_BLOCK_BYTES);

  // configuration and latched file size
  logic [psde_pkg::CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [WW-1:0]              file_w_q;
  logic [HW-1:0]              file_h_q;
  logic [31:0]                w_clamp, h_clamp;

  // pixel and stream state
  logic [7:0]    red_q, green_q, blue_q;
  logic [WW-1:0] col_q;
  logic [HW-1:0] row_q;
  logic [15:0]   block_q;
  logic [31:0]   raw_q;
  logic [31:0]   crc_q, hcrc_q;
  logic [15:0]   adl_q, adh_q;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_run_q, out_file_q;

  logic [31:0] fw32, fh32, quot, zlen, adler, crc_in;
  logic [15:0] blk, nlen;
  logic [7:0]  hdr_byte, blk_byte, raw_byte, trl_byte, cur_byte;
  logic [16:0] low_sum, high_sum;
  logic [15:0] low_new, high_new;
  logic        div_busy;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = cmd_i.in_ready;

  // clamp configured size to the supported range
  assign w_clamp = (cfg_w_q == '0) ? 32'd1 :
                   ((32'(cfg_w_q) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(cfg_w_q));
  assign h_clamp = (cfg_h_q == '0) ? 32'd1 :
                   ((32'(cfg_h_q) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(cfg_h_q));

  assign fw32 = 32'(file_w_q);
  assign fh32 = 32'(file_h_q);

  // block count for the idat length
  psde_div #(
    .STORED_BLOCK_BYTES (STORED_BLOCK_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (raw_q + 32'(BLK_MAX) - 32'd1),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign zlen  = raw_q + (quot << 2) + quot + 32'd6;
  assign blk   = (raw_q < 32'(BLK_MAX)) ? raw_q[15:0] : BLK_MAX;
  assign nlen  = ~blk;
  assign adler = {adh_q, adl_q};

  // header bytes
  always_comb begin
    case (cmd_i.idx)
      6'd0:  hdr_byte = 8'h89;
      6'd1:  hdr_byte = 8'h50;
      6'd2:  hdr_byte = 8'h4E;
      6'd3:  hdr_byte = 8'h47;
      6'd4:  hdr_byte = 8'h0D;
      6'd5:  hdr_byte = 8'h0A;
      6'd6:  hdr_byte = 8'h1A;
      6'd7:  hdr_byte = 8'h0A;
      6'd11: hdr_byte = 8'h0D;
      6'd12: hdr_byte = 8'h49;
      6'd13: hdr_byte = 8'h48;
      6'd14: hdr_byte = 8'h44;
      6'd15: hdr_byte = 8'h52;
      6'd16, 6'd17, 6'd18, 6'd19: hdr_byte = psde_pkg::be_byte(fw32, cmd_i.idx[1:0]);
      6'd20, 6'd21, 6'd22, 6'd23: hdr_byte = psde_pkg::be_byte(fh32, cmd_i.idx[1:0]);
      6'd24: hdr_byte = 8'h08;
      6'd25: hdr_byte = 8'h06;
      6'd29, 6'd30, 6'd31, 6'd32:
        hdr_byte = psde_pkg::be_byte(~hcrc_q, 2'(cmd_i.idx - psde_pkg::HDR_CRC_FIRST));
      6'd33, 6'd34, 6'd35, 6'd36:
        hdr_byte = psde_pkg::be_byte(zlen, 2'(cmd_i.idx - psde_pkg::HDR_ZLEN_FIRST));
      6'd37: hdr_byte = 8'h49;
      6'd38: hdr_byte = 8'h44;
      6'd39: hdr_byte = 8'h41;
      6'd40: hdr_byte = 8'h54;
      6'd41: hdr_byte = 8'h78;
      6'd42: hdr_byte = 8'h01;
      default: hdr_byte = 8'h00;
    endcase
  end

  // stored block header bytes
  always_comb begin
    case (cmd_i.idx)
      6'd0:    blk_byte = {7'd0, (32'(blk) == raw_q)};
      6'd1:    blk_byte = blk[7:0];
      6'd2:    blk_byte = blk[15:8];
      6'd3:    blk_byte = nlen[7:0];
      default: blk_byte = nlen[15:8];
    endcase
  end

  // pixel bytes
  always_comb begin
    case (cmd_i.sel)
      psde_pkg::SEL_FILTER: raw_byte = 8'h00;
      psde_pkg::SEL_RED:    raw_byte = red_q;
      psde_pkg::SEL_GREEN:  raw_byte = green_q;
      psde_pkg::SEL_BLUE:   raw_byte = blue_q;
      default:              raw_byte = 8'hFF;
    endcase
  end

  // trailer bytes
  always_comb begin
    case (cmd_i.idx)
      6'd0, 6'd1, 6'd2, 6'd3:     trl_byte = psde_pkg::be_byte(adler, cmd_i.idx[1:0]);
      6'd4, 6'd5, 6'd6, 6'd7:     trl_byte = psde_pkg::be_byte(~crc_q, cmd_i.idx[1:0]);
      6'd12: trl_byte = 8'h49;
      6'd13: trl_byte = 8'h45;
      6'd14: trl_byte = 8'h4E;
      6'd15: trl_byte = 8'h44;
      6'd16, 6'd17, 6'd18, 6'd19:
        trl_byte = psde_pkg::be_byte(psde_pkg::IEND_CRC, cmd_i.idx[1:0]);
      default: trl_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (cmd_i.op)
      psde_pkg::OP_HDR: cur_byte = hdr_byte;
      psde_pkg::OP_BLK: cur_byte = blk_byte;
      psde_pkg::OP_RAW: cur_byte = raw_byte;
      psde_pkg::OP_TRL: cur_byte = trl_byte;
      default:          cur_byte = 8'h00;
    endcase
  end

  // adler-32 update
  always_comb begin
    low_sum  = {1'b0, adl_q} + 17'(raw_byte);
    low_new  = (low_sum >= psde_pkg::ADLER_MOD) ? 16'(low_sum - psde_pkg::ADLER_MOD)
                                                : low_sum[15:0];
    high_sum = {1'b0, adh_q} + {1'b0, low_new};
    high_new = (high_sum >= psde_pkg::ADLER_MOD) ? 16'(high_sum - psde_pkg::ADLER_MOD)
                                                 : high_sum[15:0];
  end

  // idat crc restarts at the chunk type
  assign crc_in = ((cmd_i.op == psde_pkg::OP_HDR) && (cmd_i.idx == psde_pkg::HDR_IDAT_FIRST))
                  ? psde_pkg::CRC_INIT : crc_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= psde_pkg::CFG_W'(1);
      cfg_h_q <= psde_pkg::CFG_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        psde_pkg::REG_IMAGE_WIDTH:  cfg_w_q <= cfg_i.data;
        psde_pkg::REG_IMAGE_HEIGHT: cfg_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pixel latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pixel) begin
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
    end
  end

  // stream state and checksums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_w_q <= WW'(1);
      file_h_q <= HW'(1);
      col_q    <= '0;
      row_q    <= '0;
      block_q  <= '0;
      raw_q    <= '0;
      crc_q    <= psde_pkg::CRC_INIT;
      hcrc_q   <= psde_pkg::CRC_INIT;
      adl_q    <= 16'd1;
      adh_q    <= '0;
    end else begin
      if (cmd_i.load_size) begin
        file_w_q <= WW'(w_clamp);
        file_h_q <= HW'(h_clamp);
      end
      if (cmd_i.hdr_calc) begin
        raw_q   <= fh32 * ((fw32 << 2) + 32'd1);
        block_q <= '0;
      end
      if (cmd_i.step) begin
        case (cmd_i.op)
          psde_pkg::OP_HDR: begin
            if (cmd_i.idx == '0) begin
              hcrc_q <= psde_pkg::CRC_INIT;
            end else if ((cmd_i.idx >= psde_pkg::HDR_IHDR_FIRST) &&
                         (cmd_i.idx <= psde_pkg::HDR_IHDR_LAST)) begin
              hcrc_q <= psde_pkg::crc_byte(hcrc_q, cur_byte);
            end
            if (cmd_i.idx >= psde_pkg::HDR_IDAT_FIRST) begin
              crc_q <= psde_pkg::crc_byte(crc_in, cur_byte);
            end
          end
          psde_pkg::OP_BLK: begin
            crc_q <= psde_pkg::crc_byte(crc_q, cur_byte);
            if (cmd_i.idx == psde_pkg::BLK_LAST) begin
              block_q <= blk;
            end
          end
          psde_pkg::OP_RAW: begin
            crc_q <= psde_pkg::crc_byte(crc_q, cur_byte);
            adl_q <= low_new;
            adh_q <= high_new;
            if (block_q != '0) begin
              block_q <= block_q - 16'd1;
            end
            if (raw_q != '0) begin
              raw_q <= raw_q - 32'd1;
            end
            if (cmd_i.sel == psde_pkg::SEL_ALPHA) begin
              if (status_o.col_last) begin
                col_q <= '0;
                row_q <= row_q + 1'b1;
              end else begin
                col_q <= col_q + 1'b1;
              end
            end
          end
          psde_pkg::OP_TRL: begin
            if (cmd_i.idx <= psde_pkg::TRL_ADLER_LAST) begin
              crc_q <= psde_pkg::crc_byte(crc_q, cur_byte);
            end
            if (cmd_i.file_reset) begin
              file_w_q <= WW'(1);
              file_h_q <= HW'(1);
              col_q    <= '0;
              row_q    <= '0;
              block_q  <= '0;
              raw_q    <= '0;
              crc_q    <= psde_pkg::CRC_INIT;
              adl_q    <= 16'd1;
              adh_q    <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= cur_byte;
      out_run_q  <= cmd_i.run_end;
      out_file_q <= cmd_i.file_end;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.out_byte = out_byte_q;
  assign res_o.run_end  = out_run_q;
  assign res_o.file_end = out_file_q;

  // status towards the sequencer
  assign status_o.slot_free   = !out_valid_q || res_o.ready;
  assign status_o.pix_valid   = pix_i.valid;
  assign status_o.block_empty = (block_q == '0);
  assign status_o.col_zero    = (col_q == '0);
  assign status_o.col_last    = (32'(col_q) + 32'd1 >= fw32);
  assign status_o.row_last    = (32'(row_q) + 32'd1 >= fh32);
  assign status_o.div_busy    = div_busy;

endmodule

@@ hdl/png_stored_deflate_encoder.sv @@
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder
// RGB pixels in, an uncompressed 8-bit RGBA PNG byte stream out.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i  : one rgb pixel per transaction, raster order.
//   res_o  : one file byte per transaction; run_end marks the last byte caused
//            by a pixel, file_end the last byte of the IEND chunk.
//   cfg_i  : register writes (0 image_width, 1 image_height), always ready,
//            sizes clamped and latched when a file's header starts.
// A pixel is taken only while the sequencer is idle, then one byte per cycle
// while the receiver is ready: 4 bytes, plus a filter byte at row start; a
// stored block header adds 5 more once the sequencer spots the empty block.
// The first pixel of a file adds 43 header bytes; the block count for the
// idat length comes from a reciprocal multiply (dividend latched, quotient
// registered), ready long before the length bytes. The last pixel adds 20
// trailer bytes, or the next pixel if they do not fit the 64-byte window.
// A stalled receiver holds the output register and stops the sequencer; the
// next pixel is taken once the current pixel's bytes have all been produced.
// Reset clears all file state; the next pixel opens a new file.
// ----------------------------------------------------------------------------
module png_stored_deflate_encoder #(
  parameter int unsigned MAX_WIDTH          = psde_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT         = psde_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned STORED_BLOCK_BYTES = psde_pkg::DEF_BLOCK_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  psde_pix_if.sink     pix_i,
  psde_byte_if.source  res_o,
  psde_cfg_if.sink     cfg_i
);

  psde_pkg::cmd_t    cmd;
  psde_pkg::status_t status;

  // sequencer
  psde_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // datapath
  psde_dpath #(
    .MAX_WIDTH          (MAX_WIDTH),
    .MAX_HEIGHT         (MAX_HEIGHT),
    .STORED_BLOCK_BYTES (STORED_BLOCK_BYTES)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .res_o    (res_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

  // end of file is always the end of a run
  a_file_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.file_end |-> res_o.run_end)
    else $error("file_end without run_end");

  // the sequencer never overwrites a byte still waiting
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.slot_free)
    else $error("byte emitted into a full output register");

  // no pixel is taken while the length division runs
  a_div_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !pix_i.ready)
    else $error("pixel ready during header division");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stored-deflate png encoder: pixels are driven
// file by file under several image sizes and back-pressure patterns, and
// every output byte is compared against a behavioural model of the stream.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned BLOCK_BYTES    = psde_pkg::DEF_BLOCK_BYTES;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       file_end;
  } png_byte_t;

  // png stream model and scoreboard
  class png_stream_sb;
    int unsigned     width_reg, height_reg;
    int unsigned     col, row, blk_left, raw_left, crc, adler_lo, adler_hi;
    int unsigned     file_w, file_h, step_cnt;
    bit              hdr_done, trl_pend;
    png_byte_t       bytes_q[$];
    int unsigned     errors;

    function new();
      width_reg  = 1;
      height_reg = 1;
      errors     = 0;
      clear_file();
    endfunction

    function void clear_file();
      col = 0; row = 0; blk_left = 0; raw_left = 0;
      crc = 32'hFFFFFFFF; adler_lo = 1; adler_hi = 0;
      hdr_done = 0; trl_pend = 0; file_w = 1; file_h = 1;
    endfunction

    function bit in_file();
      return hdr_done || trl_pend;
    endfunction

    function int unsigned crc_step(int unsigned c, logic [7:0] b);
      logic [31:0] v;
      v = c ^ b;
      for (int k = 0; k < 8; k++) v = v[0] ? (psde_pkg::CRC_POLY ^ (v >> 1)) : (v >> 1);
      return v;
    endfunction

    function void push(logic [7:0] b, bit fin);
      png_byte_t e;
      if (step_cnt < psde_pkg::RESULT_LIMIT) begin
        e.data = b; e.run_end = 0; e.file_end = fin;
        bytes_q = {bytes_q, e};
        step_cnt++;
      end
    endfunction

    function void push_idat(logic [7:0] b);
      crc = crc_step(crc, b);
      push(b, 0);
    endfunction

    function void push_word(logic [31:0] v);
      push(v[31:24], 0); push(v[23:16], 0); push(v[15:8], 0); push(v[7:0], 0);
    endfunction

    function void push_raw(logic [7:0] b);
      int unsigned blk;
      logic [15:0] nlen;
      if (blk_left == 0) begin
        blk  = raw_left < BLOCK_BYTES ? raw_left : BLOCK_BYTES;
        nlen = ~blk[15:0];
        push_idat(blk == raw_left ? 8'd1 : 8'd0);
        push_idat(blk[7:0]);
        push_idat(blk[15:8]);
        push_idat(nlen[7:0]);
        push_idat(nlen[15:8]);
        blk_left = blk;
      end
      push_idat(b);
      adler_lo += b;
      if (adler_lo >= 65521) adler_lo -= 65521;
      adler_hi += adler_lo;
      if (adler_hi >= 65521) adler_hi -= 65521;
      if (blk_left != 0) blk_left--;
      if (raw_left != 0) raw_left--;
    endfunction

    function void put_header();
      logic [7:0]  sig [8];
      logic [7:0]  ih [17];
      int unsigned raw_total, blocks, zlen, hcrc;
      sig = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
      file_w = width_reg < 1 ? 1 : (width_reg > psde_pkg::DEF_MAX_WIDTH ?
                                    psde_pkg::DEF_MAX_WIDTH : width_reg);
      file_h = height_reg < 1 ? 1 : (height_reg > psde_pkg::DEF_MAX_HEIGHT ?
                                     psde_pkg::DEF_MAX_HEIGHT : height_reg);
      raw_total = file_h * (1 + 4 * file_w);
      blocks    = (raw_total + BLOCK_BYTES - 1) / BLOCK_BYTES;
      zlen      = 2 + raw_total + 5 * blocks + 4;
      raw_left  = raw_total;
      blk_left  = 0;
      foreach (sig[i]) push(sig[i], 0);
      ih = '{"I", "H", "D", "R", 0, 0, 0, 0, 0, 0, 0, 0, 8, 6, 0, 0, 0};
      for (int i = 0; i < 4; i++) begin
        ih[4 + i] = 8'(file_w >> (24 - 8 * i));
        ih[8 + i] = 8'(file_h >> (24 - 8 * i));
      end
      push_word(32'd13);
      hcrc = 32'hFFFFFFFF;
      foreach (ih[i]) begin
        hcrc = crc_step(hcrc, ih[i]);
        push(ih[i], 0);
      end
      push_word(~hcrc);
      push_word(zlen);
      crc = 32'hFFFFFFFF;
      push_idat("I"); push_idat("D"); push_idat("A"); push_idat("T");
      push_idat(8'h78); push_idat(8'h01);
      hdr_done = 1;
    endfunction

    function void put_trailer();
      logic [31:0] adler, fin;
      logic [7:0]  iend [4];
      int unsigned ecrc;
      iend  = '{"I", "E", "N", "D"};
      adler = {adler_hi[15:0], adler_lo[15:0]};
      push_idat(adler[31:24]); push_idat(adler[23:16]);
      push_idat(adler[15:8]);  push_idat(adler[7:0]);
      push_word(~crc);
      push_word(32'd0);
      ecrc = 32'hFFFFFFFF;
      foreach (iend[i]) begin
        ecrc = crc_step(ecrc, iend[i]);
        push(iend[i], 0);
      end
      fin = ~ecrc;
      push(fin[31:24], 0); push(fin[23:16], 0); push(fin[15:8], 0); push(fin[7:0], 1);
      clear_file();
    endfunction

    // accepted pixel: append the bytes it causes
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      step_cnt = 0;
      if (trl_pend) put_trailer();
      else begin
        if (!hdr_done) put_header();
        if (col == 0) push_raw(8'h00);
        push_raw(r); push_raw(g); push_raw(b); push_raw(8'hFF);
        col++;
        if (col >= file_w) begin
          col = 0;
          row++;
          if (row >= file_h) begin
            if (step_cnt + psde_pkg::TRAILER_BYTES <= psde_pkg::RESULT_LIMIT) put_trailer();
            else trl_pend = 1;
          end
        end
      end
      if (step_cnt > 0) bytes_q[bytes_q.size() - 1].run_end = 1;
    endfunction

    // accepted output byte against the oldest expected one
    function void check_byte(logic [7:0] d, logic re, logic fe);
      png_byte_t e;
      if (bytes_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected byte %02h run_end %b file_end %b", d, re, fe);
        return;
      end
      e = bytes_q.pop_front();
      if (d !== e.data || re !== e.run_end || fe !== e.file_end) begin
        errors++;
        if (errors <= 10)
          $display("byte mismatch: expected %02h/%b/%b actual %02h/%b/%b",
                   e.data, e.run_end, e.file_end, d, re, fe);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned pix_idle = 0;
  int unsigned res_stall = 0;
  int unsigned quiet_cycles = 0;
  png_stream_sb sb;

  psde_pix_if  pix ();
  psde_byte_if res ();
  psde_cfg_if  cfg ();

  png_stored_deflate_encoder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always #10 clk = ~clk;

  initial begin
    pix.valid = 1'b0; pix.red = '0; pix.green = '0; pix.blue = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    res.ready = 1'b0;
    sb = new();
  end

  // output side: check each byte transaction, random stalls
  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) sb.check_byte(res.out_byte, res.run_end, res.file_end);
    res.ready <= ($urandom_range(99) >= res_stall);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < pix_idle) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.note_pixel(r, g, b);
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (sb.bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [psde_pkg::INDEX_W-1:0] idx,
                           logic [psde_pkg::CFG_W-1:0] val);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == psde_pkg::REG_IMAGE_WIDTH) sb.width_reg = val;
    else sb.height_reg = val;
  endtask

  // one whole file of random pixels at the current size
  task automatic send_file(output int unsigned n);
    n = 0;
    do begin
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      n++;
    end while (sb.in_file());
  endtask

  initial begin
    int unsigned sent, n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size 1x1: the trailer is held back to the next pixel
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    // zero sizes clamp to one
    write_reg(psde_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_reg(psde_pkg::REG_IMAGE_HEIGHT, 13'd0);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    send_pixel(8'h55, 8'hFF, 8'h00);
    // small image with field extremes
    write_reg(psde_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(psde_pkg::REG_IMAGE_HEIGHT, 13'd2);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'h01, 8'h80, 8'h7F);
    send_pixel(8'hFE, 8'h7F, 8'h80);

    // random sizes under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin pix_idle = 0;  res_stall = 0;  end
        1: begin pix_idle = 77; res_stall = 0;  end
        2: begin pix_idle = 0;  res_stall = 77; end
        default: begin pix_idle = 31; res_stall = 31; end
      endcase
      sent = 0;
      while (sent < 30) begin
        write_reg(psde_pkg::REG_IMAGE_WIDTH, psde_pkg::CFG_W'($urandom_range(6, 1)));
        write_reg(psde_pkg::REG_IMAGE_HEIGHT, psde_pkg::CFG_W'($urandom_range(4, 1)));
        send_file(n);
        sent += n;
      end
    end

    // oversize sizes clamp to the maximum: start of such a file only
    write_reg(psde_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(psde_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 12; i++) begin
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    end

    wait_idle();
    if (sb.errors == 0 && sb.bytes_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
